// File: sv/mae_pkg.sv
// Shared types, codes and helper functions for the matrix arithmetic engine.
`timescale 1ns / 1ps
package mae_pkg;

    localparam int MaxDim   = 8;
    localparam int DimW     = 3;
    localparam int DimCntW  = 4;
    localparam int AddrW    = 2 * DimW;
    localparam int Depth    = MaxDim * MaxDim;
    localparam int DataW    = 32;
    localparam int ProdW    = 64;
    localparam int AccW     = 68;
    localparam int FracW    = 16;
    localparam int DivQW    = DataW + FracW;
    localparam int DivCntW  = 6;
    localparam int CfgIdxW  = 3;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    // Operation codes held in the op_mode register.
    localparam logic [2:0] OP_MUL   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_ADDSC = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SIZE     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_DIV_ZERO = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_OP     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROWS_A = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_COLS_A = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ROWS_B = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COLS_B = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SCALAR = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic [AddrW-1:0] a_addr;
        logic [AddrW-1:0] b_addr;
        logic             capture;
        logic             acc_en;
        logic             acc_clr;
        logic             div_start;
        logic             fin;
        logic             err;
        logic [1:0]       err_status;
        logic [DimW-1:0]  out_row;
        logic [DimW-1:0]  out_col;
        logic             last;
    } t_cmd;

    // Clamp a dimension register into 1..MaxDim.
    function automatic logic [DimCntW-1:0] sat_dim(input logic [DimCntW-1:0] v);
        logic [DimCntW-1:0] r;
        if (v == '0) begin
            r = DimCntW'(1);
        end else if (v > DimCntW'(MaxDim)) begin
            r = DimCntW'(MaxDim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
        logic [DataW-1:0] r;
        if (x > 68'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (x < -68'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[DataW-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/matrix_arithmetic_engine_unit.sv
// Top level: configuration registers, stream ports, controller and datapath.
// A load is written straight into its matrix store; an error result passes through the
// result register, then the output register. Per element: each dot product term is read,
// multiplied and accumulated on one shared unit; divide waits on the serial divider.
// One item is handled at a time; an output register holds the final result meanwhile.
// Synchronous active-low reset: op_mode 0, dimensions 1, scalar 0, output empty.
`timescale 1ns / 1ps
module matrix_arithmetic_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: row [2:0], col [5:3], value [37:6], zero fill [39:38]
    input  logic [mae_pkg::InDataW-1:0]    i_s_axis_tdata,
    // tuser: kind [1:0]
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: out_row [2:0], out_col [5:3], out_value [37:6], zero fill [39:38]
    output logic [mae_pkg::OutDataW-1:0]   o_m_axis_tdata,
    // tuser: status [1:0]
    output logic [1:0]                     o_m_axis_tuser,
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [mae_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [mae_pkg::DataW-1:0]      i_cfg_data
);

    logic [2:0]                     r_op;
    logic [mae_pkg::DimCntW-1:0]    r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [mae_pkg::DataW-1:0]      r_scalar;
    mae_pkg::t_cmd                  w_cmd;
    logic                           w_div_done;
    logic [mae_pkg::DimW-1:0]       w_out_row, w_out_col;
    logic [mae_pkg::DataW-1:0]      w_out_value;
    logic [1:0]                     w_status;
    logic                           w_last;
    logic                           w_res_valid;
    logic                           w_res_ready;
    logic                           r_m_valid;
    logic [mae_pkg::OutDataW-1:0]   r_m_tdata;
    logic [1:0]                     r_m_tuser;
    logic                           r_m_tlast;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= mae_pkg::OP_MUL;
            r_rows_a <= 4'd1;
            r_cols_a <= 4'd1;
            r_rows_b <= 4'd1;
            r_cols_b <= 4'd1;
            r_scalar <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mae_pkg::REG_OP:     r_op     <= i_cfg_data[2:0];
                mae_pkg::REG_ROWS_A: r_rows_a <= i_cfg_data[3:0];
                mae_pkg::REG_COLS_A: r_cols_a <= i_cfg_data[3:0];
                mae_pkg::REG_ROWS_B: r_rows_b <= i_cfg_data[3:0];
                mae_pkg::REG_COLS_B: r_cols_b <= i_cfg_data[3:0];
                mae_pkg::REG_SCALAR: r_scalar <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mae_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_kind        (i_s_axis_tuser),
        .i_row         (i_s_axis_tdata[2:0]),
        .i_col         (i_s_axis_tdata[5:3]),
        .i_op          (r_op),
        .i_rows_a      (r_rows_a),
        .i_cols_a      (r_cols_a),
        .i_rows_b      (r_rows_b),
        .i_cols_b      (r_cols_b),
        .i_scalar_zero (r_scalar == '0),
        .i_div_done    (w_div_done),
        .o_out_valid   (w_res_valid),
        .i_out_ready   (w_res_ready),
        .o_cmd         (w_cmd)
    );

    mae_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (r_op),
        .i_scalar    (r_scalar),
        .i_ld_row    (i_s_axis_tdata[2:0]),
        .i_ld_col    (i_s_axis_tdata[5:3]),
        .i_ld_value  (i_s_axis_tdata[37:6]),
        .o_div_done  (w_div_done),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_value (w_out_value),
        .o_status    (w_status),
        .o_last      (w_last)
    );

    // Output register: takes a result when empty or when its transaction leaves.
    assign w_res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_tdata <= {2'b00, w_out_value, w_out_col, w_out_row};
            r_m_tuser <= w_status;
            r_m_tlast <= w_last;
        end
    end

    // Pack the result transaction.
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;
    assign o_m_axis_tlast  = r_m_tlast;

endmodule

// File: sv/mae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mae_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mae_datapath.sv
// Datapath: matrix stores, shared multiplier, accumulator, divider and result register.
`timescale 1ns / 1ps
module mae_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mae_pkg::t_cmd               i_cmd,
    input  logic [2:0]                  i_op,
    input  logic [mae_pkg::DataW-1:0]   i_scalar,
    input  logic [mae_pkg::DimW-1:0]    i_ld_row,
    input  logic [mae_pkg::DimW-1:0]    i_ld_col,
    input  logic [mae_pkg::DataW-1:0]   i_ld_value,
    output logic                        o_div_done,
    output logic [mae_pkg::DimW-1:0]    o_out_row,
    output logic [mae_pkg::DimW-1:0]    o_out_col,
    output logic [mae_pkg::DataW-1:0]   o_out_value,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    logic [mae_pkg::AddrW-1:0]        w_waddr;
    logic [mae_pkg::DataW-1:0]        w_a;
    logic [mae_pkg::DataW-1:0]        w_b;
    logic [mae_pkg::DataW-1:0]        w_rhs;
    logic signed [mae_pkg::ProdW-1:0] w_mul;
    logic signed [mae_pkg::ProdW-1:0] w_sum;
    logic signed [mae_pkg::ProdW-1:0] r_prod;
    logic signed [mae_pkg::AccW-1:0]  r_acc;
    logic [mae_pkg::DataW-1:0]        w_a_mag;
    logic [mae_pkg::DataW-1:0]        w_s_mag;
    logic [mae_pkg::DivQW-1:0]        r_q;
    logic [mae_pkg::DataW:0]          r_rem;
    logic [mae_pkg::DataW-1:0]        r_dvs;
    logic                             r_qneg;
    logic [mae_pkg::DivCntW-1:0]      r_div_cnt;
    logic [mae_pkg::DataW:0]          w_rem_sh;
    logic                             w_ge;
    logic signed [mae_pkg::AccW-1:0]  w_q_signed;
    logic signed [mae_pkg::AccW-1:0]  w_fin;
    logic [mae_pkg::DimW-1:0]         r_out_row;
    logic [mae_pkg::DimW-1:0]         r_out_col;
    logic [mae_pkg::DataW-1:0]        r_out_value;
    logic [1:0]                       r_status;
    logic                             r_last;

    function automatic logic signed [mae_pkg::ProdW-1:0] ProdSext(input logic [31:0] v);
        return {{(mae_pkg::ProdW - mae_pkg::DataW){v[31]}}, v};
    endfunction

    assign w_waddr = {i_ld_row, i_ld_col};

    mae_ram #(.Width(mae_pkg::DataW), .Depth(mae_pkg::Depth)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (w_waddr),
        .i_wdata (i_ld_value),
        .i_raddr (i_cmd.a_addr),
        .o_rdata (w_a)
    );

    mae_ram #(.Width(mae_pkg::DataW), .Depth(mae_pkg::Depth)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (w_waddr),
        .i_wdata (i_ld_value),
        .i_raddr (i_cmd.b_addr),
        .o_rdata (w_b)
    );

    // Second operand is a B element or the scalar, depending on the operation.
    assign w_rhs = (i_op == mae_pkg::OP_MUL || i_op == mae_pkg::OP_ADD) ? w_b : i_scalar;
    assign w_mul = $signed(w_a) * $signed(w_rhs);
    assign w_sum = ProdSext(w_a) + ProdSext(w_rhs);

    // Product or sum register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (i_op == mae_pkg::OP_ADD || i_op == mae_pkg::OP_ADDSC) begin
                r_prod <= w_sum;
            end else begin
                r_prod <= w_mul;
            end
        end
    end

    // Dot product accumulator, exact products summed before the final shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_acc <= (i_cmd.acc_clr ? '0 : r_acc) + mae_pkg::AccW'(r_prod);
        end
    end

    // Magnitudes for the divider.
    assign w_a_mag  = w_a[31] ? (~w_a + 32'd1) : w_a;
    assign w_s_mag  = i_scalar[31] ? (~i_scalar + 32'd1) : i_scalar;
    assign w_rem_sh = {r_rem[mae_pkg::DataW-1:0], r_q[mae_pkg::DivQW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    // Restoring divider, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= mae_pkg::DivCntW'(mae_pkg::DivQW);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_q    <= {w_a_mag, {mae_pkg::FracW{1'b0}}};
            r_rem  <= '0;
            r_dvs  <= w_s_mag;
            r_qneg <= w_a[31] ^ i_scalar[31];
        end else if (r_div_cnt != '0) begin
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
            r_q   <= {r_q[mae_pkg::DivQW-2:0], w_ge};
        end
    end

    assign o_div_done = (r_div_cnt == '0);

    // Final value before saturation.
    assign w_q_signed = r_qneg ? -$signed({20'd0, r_q}) : $signed({20'd0, r_q});

    always_comb begin
        unique case (i_op)
            mae_pkg::OP_MUL:   w_fin = r_acc >>> mae_pkg::FracW;
            mae_pkg::OP_SCALE: w_fin = mae_pkg::AccW'(r_prod >>> mae_pkg::FracW);
            mae_pkg::OP_DIV:   w_fin = w_q_signed;
            default:           w_fin = mae_pkg::AccW'(r_prod);
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_status    <= i_cmd.err_status;
            r_last      <= 1'b1;
        end else if (i_cmd.fin) begin
            r_out_row   <= i_cmd.out_row;
            r_out_col   <= i_cmd.out_col;
            r_out_value <= mae_pkg::sat32(w_fin);
            r_status    <= mae_pkg::ST_OK;
            r_last      <= i_cmd.last;
        end
    end

    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// File: sv/mae_ctrl.sv
// Controller: sequences loads, checks and the element loops of each operation.
`timescale 1ns / 1ps
module mae_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [mae_pkg::DimW-1:0]      i_row,
    input  logic [mae_pkg::DimW-1:0]      i_col,
    input  logic [2:0]                    i_op,
    input  logic [mae_pkg::DimCntW-1:0]   i_rows_a,
    input  logic [mae_pkg::DimCntW-1:0]   i_cols_a,
    input  logic [mae_pkg::DimCntW-1:0]   i_rows_b,
    input  logic [mae_pkg::DimCntW-1:0]   i_cols_b,
    input  logic                          i_scalar_zero,
    input  logic                          i_div_done,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mae_pkg::t_cmd                 o_cmd
);

    mae_pkg::t_state                r_state, n_state;
    logic [mae_pkg::DimW-1:0]       r_i, n_i, r_j, n_j, r_k, n_k;
    logic                           r_err, n_err;
    logic [mae_pkg::DimCntW-1:0]    w_ra, w_ca, w_rb, w_cb, w_nc, w_mr, w_mc;
    logic                           w_acc_in;
    logic                           w_last;

    assign w_ra = mae_pkg::sat_dim(i_rows_a);
    assign w_ca = mae_pkg::sat_dim(i_cols_a);
    assign w_rb = mae_pkg::sat_dim(i_rows_b);
    assign w_cb = mae_pkg::sat_dim(i_cols_b);
    assign w_nc = (i_op == mae_pkg::OP_MUL) ? w_cb : w_ca;
    assign w_mr = (i_kind == mae_pkg::KIND_LOAD_A) ? w_ra : w_rb;
    assign w_mc = (i_kind == mae_pkg::KIND_LOAD_A) ? w_ca : w_cb;

    assign o_in_ready  = (r_state == mae_pkg::S_IDLE);
    assign o_out_valid = (r_state == mae_pkg::S_OUT);
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign w_last      = ({1'b0, r_i} == w_ra - 1'b1) && ({1'b0, r_j} == w_nc - 1'b1);

    // State and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mae_pkg::S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_err   <= n_err;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.a_addr  = (i_op == mae_pkg::OP_MUL) ? {r_i, r_k} : {r_i, r_j};
        o_cmd.b_addr  = (i_op == mae_pkg::OP_MUL) ? {r_k, r_j} : {r_i, r_j};
        o_cmd.out_row = r_i;
        o_cmd.out_col = r_j;
        o_cmd.last    = w_last;
        o_cmd.acc_clr = (r_k == '0);
        unique case (r_state)
            mae_pkg::S_IDLE: begin
                n_i   = '0;
                n_j   = '0;
                n_k   = '0;
                n_err = 1'b0;
                if (w_acc_in) begin
                    priority if (i_kind == mae_pkg::KIND_LOAD_A
                                 || i_kind == mae_pkg::KIND_LOAD_B) begin
                        if ({1'b0, i_row} >= w_mr || {1'b0, i_col} >= w_mc) begin
                            o_cmd.err        = 1'b1;
                            o_cmd.err_status = mae_pkg::ST_RANGE;
                            n_err            = 1'b1;
                            n_state          = mae_pkg::S_OUT;
                        end else begin
                            o_cmd.wr_a = (i_kind == mae_pkg::KIND_LOAD_A);
                            o_cmd.wr_b = (i_kind == mae_pkg::KIND_LOAD_B);
                        end
                    end else if (i_kind != mae_pkg::KIND_START || i_op > mae_pkg::OP_DIV) begin
                        n_state = mae_pkg::S_IDLE;
                    end else if (i_op == mae_pkg::OP_MUL && w_ca != w_rb) begin
                        o_cmd.err        = 1'b1;
                        o_cmd.err_status = mae_pkg::ST_SIZE;
                        n_err            = 1'b1;
                        n_state          = mae_pkg::S_OUT;
                    end else if (i_op == mae_pkg::OP_ADD && (w_ra != w_rb || w_ca != w_cb)) begin
                        o_cmd.err        = 1'b1;
                        o_cmd.err_status = mae_pkg::ST_SIZE;
                        n_err            = 1'b1;
                        n_state          = mae_pkg::S_OUT;
                    end else if (i_op == mae_pkg::OP_DIV && i_scalar_zero) begin
                        o_cmd.err        = 1'b1;
                        o_cmd.err_status = mae_pkg::ST_DIV_ZERO;
                        n_err            = 1'b1;
                        n_state          = mae_pkg::S_OUT;
                    end else begin
                        n_state = mae_pkg::S_RD;
                    end
                end
            end
            mae_pkg::S_RD: begin
                n_state = mae_pkg::S_MUL;
            end
            mae_pkg::S_MUL: begin
                o_cmd.capture   = 1'b1;
                o_cmd.div_start = (i_op == mae_pkg::OP_DIV);
                priority if (i_op == mae_pkg::OP_MUL) begin
                    n_state = mae_pkg::S_ACC;
                end else if (i_op == mae_pkg::OP_DIV) begin
                    n_state = mae_pkg::S_DIV;
                end else begin
                    n_state = mae_pkg::S_FIN;
                end
            end
            mae_pkg::S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if ({1'b0, r_k} == w_ca - 1'b1) begin
                    n_state = mae_pkg::S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = mae_pkg::S_RD;
                end
            end
            mae_pkg::S_DIV: begin
                if (i_div_done) begin
                    n_state = mae_pkg::S_FIN;
                end
            end
            mae_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = mae_pkg::S_OUT;
            end
            mae_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_k = '0;
                    // An error result is always the only one of its run.
                    priority if (r_err || w_last) begin
                        n_state = mae_pkg::S_IDLE;
                    end else if ({1'b0, r_j} == w_nc - 1'b1) begin
                        n_j     = '0;
                        n_i     = r_i + 1'b1;
                        n_state = mae_pkg::S_RD;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = mae_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = mae_pkg::S_IDLE;
            end
        endcase
    end

endmodule
